[design/ohm_fmt_pkg.sv]
// ----------------------------------------------------------------------------
// ohm_fmt_pkg: ohmmeter display formatter package
// Display codes, decade bounds, range limits and the reciprocal constants
// used to keep the leading four decimal digits of a reading.
// ----------------------------------------------------------------------------
package ohm_fmt_pkg;

	localparam int MW = 37;
	localparam int XW = 30;
	localparam int QW = 14;

	localparam logic [3:0] DIG_L     = 4'd10;
	localparam logic [3:0] DIG_BLANK = 4'd11;
	localparam logic [3:0] DIG_ZERO  = 4'd0;

	localparam logic [1:0] UNIT_NONE = 2'd0;
	localparam logic [1:0] UNIT_OHM  = 2'd1;
	localparam logic [1:0] UNIT_KILO = 2'd2;
	localparam logic [1:0] UNIT_MEGA = 2'd3;

	localparam logic [1:0] STAT_NORMAL = 2'd0;
	localparam logic [1:0] STAT_OVER   = 2'd1;
	localparam logic [1:0] STAT_UNDER  = 2'd2;

	localparam logic [1:0] PT_NONE = 2'd0;
	localparam logic [1:0] PT_1    = 2'd1;
	localparam logic [1:0] PT_2    = 2'd2;
	localparam logic [1:0] PT_3    = 2'd3;

	localparam logic [3:0] RANGE_OFF  = 4'd0;
	localparam logic [3:0] RANGE_20R  = 4'd1;
	localparam logic [3:0] RANGE_200R = 4'd2;
	localparam logic [3:0] RANGE_2K   = 4'd3;
	localparam logic [3:0] RANGE_20K  = 4'd4;
	localparam logic [3:0] RANGE_200K = 4'd5;
	localparam logic [3:0] RANGE_2M   = 4'd6;
	localparam logic [3:0] RANGE_20M  = 4'd7;
	localparam logic [3:0] RANGE_RST  = RANGE_20R;

	localparam logic REG_RANGE = 1'b0;

	localparam logic [MW-1:0] DEC_2  = 37'd100;
	localparam logic [MW-1:0] DEC_4  = 37'd10000;
	localparam logic [MW-1:0] DEC_5  = 37'd100000;
	localparam logic [MW-1:0] DEC_6  = 37'd1000000;
	localparam logic [MW-1:0] DEC_7  = 37'd10000000;
	localparam logic [MW-1:0] DEC_8  = 37'd100000000;
	localparam logic [MW-1:0] DEC_9  = 37'd1000000000;
	localparam logic [MW-1:0] DEC_10 = 37'd10000000000;
	localparam logic [MW-1:0] DEC_11 = 37'd100000000000;

	localparam logic [MW-1:0] OVER_1 = 37'd20000;
	localparam logic [MW-1:0] OVER_2 = 37'd200000;
	localparam logic [MW-1:0] OVER_3 = 37'd2000000;
	localparam logic [MW-1:0] OVER_4 = 37'd20000000;
	localparam logic [MW-1:0] OVER_5 = 37'd200000000;
	localparam logic [MW-1:0] OVER_6 = 37'd2000000000;
	localparam logic [MW-1:0] OVER_7 = 37'd22000000000;

	localparam logic [MW-1:0] UNDER_1 = 37'd400;
	localparam logic [MW-1:0] UNDER_2 = 37'd3000;
	localparam logic [MW-1:0] UNDER_3 = 37'd30000;
	localparam logic [MW-1:0] UNDER_4 = 37'd300000;
	localparam logic [MW-1:0] UNDER_5 = 37'd3000000;
	localparam logic [MW-1:0] UNDER_6 = 37'd200000000;
	localparam logic [MW-1:0] UNDER_7 = 37'd2000000000;

	// m / 10^k = (m >> k) / 5^k, taken as ((m >> k) * RCP_k) >> SH_k
	localparam logic [5:0] SH_1 = 6'd18;
	localparam logic [5:0] SH_2 = 6'd23;
	localparam logic [5:0] SH_3 = 6'd28;
	localparam logic [5:0] SH_4 = 6'd32;
	localparam logic [5:0] SH_5 = 6'd37;
	localparam logic [5:0] SH_6 = 6'd42;
	localparam logic [5:0] SH_7 = 6'd46;

	localparam logic [XW-1:0] RCP_1 = XW'(((64'd1 << 18) + 64'd4) / 64'd5);
	localparam logic [XW-1:0] RCP_2 = XW'(((64'd1 << 23) + 64'd24) / 64'd25);
	localparam logic [XW-1:0] RCP_3 = XW'(((64'd1 << 28) + 64'd124) / 64'd125);
	localparam logic [XW-1:0] RCP_4 = XW'(((64'd1 << 32) + 64'd624) / 64'd625);
	localparam logic [XW-1:0] RCP_5 = XW'(((64'd1 << 37) + 64'd3124) / 64'd3125);
	localparam logic [XW-1:0] RCP_6 = XW'(((64'd1 << 42) + 64'd15624) / 64'd15625);
	localparam logic [XW-1:0] RCP_7 = XW'(((64'd1 << 46) + 64'd78124) / 64'd78125);

	function automatic logic [XW-1:0] rcp_sel(input logic [2:0] k);
		logic [XW-1:0] r;
		case (k)
			3'd1: r = RCP_1;
			3'd2: r = RCP_2;
			3'd3: r = RCP_3;
			3'd4: r = RCP_4;
			3'd5: r = RCP_5;
			3'd6: r = RCP_6;
			3'd7: r = RCP_7;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] sh_sel(input logic [2:0] k);
		logic [5:0] s;
		case (k)
			3'd1: s = SH_1;
			3'd2: s = SH_2;
			3'd3: s = SH_3;
			3'd4: s = SH_4;
			3'd5: s = SH_5;
			3'd6: s = SH_6;
			3'd7: s = SH_7;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

[design/ohmmeter_display_formatter.sv]
// ----------------------------------------------------------------------------
// ohmmeter_display_formatter: resistance reading to seven-segment frame
// Classifies a milliohm reading by decade, applies the range limits and
// splits the leading four decimal digits for a four-digit display.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while frame_stall is low; a three-stage pipeline
// (input register, reciprocal multiply, digit split) with each stage filling while
// the next holds, so items are taken while a finished frame still waits.
// Reset: range_q returns to 1 (20R); all pipeline valid bits clear.
module ohmmeter_display_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        reading_valid,
	output logic        reading_stall,
	input  logic [36:0] resistance_milliohm,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [3:0]  digit0,
	output logic [3:0]  digit1,
	output logic [3:0]  digit2,
	output logic [3:0]  digit3,
	output logic [1:0]  point_after,
	output logic [1:0]  unit_code,
	output logic [1:0]  status
);
	import ohm_fmt_pkg::*;

	logic [3:0]    range_q;
	logic          v_s1, v_s2, v_s3;
	logic          en1, en2, en3;
	logic [MW-1:0] m_s1;

	logic [QW-1:0] q_s2;
	logic [1:0]    point_s2, unit_s2, stat_s2;

	logic [3:0]    d0_s3, d1_s3, d2_s3, d3_s3;
	logic [1:0]    point_s3, unit_s3, stat_s3;

	logic          over, under;
	logic [1:0]    point_c, unit_c, stat_c, point_n;
	logic [2:0]    k;
	logic [XW-1:0] x;
	logic [59:0]   prod;
	logic [QW-1:0] q_n;

	logic [3:0]    th, hu, te, on;
	logic [QW-1:0] rem1, rem2, rem3;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RANGE) ? {28'd0, range_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_RANGE) begin
			range_q <= pwdata[3:0];
		end
	end

	assign en3 = !v_s3 || !frame_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign reading_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= reading_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// classify, check limits, pick decade shift
	always_comb begin
		if (m_s1 >= DEC_11) begin
			unit_c = UNIT_NONE; point_c = PT_NONE; k = 3'd7;
		end else if (m_s1 >= DEC_10) begin
			unit_c = UNIT_MEGA; point_c = PT_2; k = 3'd7;
		end else if (m_s1 >= DEC_9) begin
			unit_c = UNIT_MEGA; point_c = PT_1; k = 3'd6;
		end else if (m_s1 >= DEC_8) begin
			unit_c = UNIT_KILO; point_c = PT_3; k = 3'd5;
		end else if (m_s1 >= DEC_7) begin
			unit_c = UNIT_KILO; point_c = PT_2; k = 3'd4;
		end else if (m_s1 >= DEC_6) begin
			unit_c = UNIT_KILO; point_c = PT_1; k = 3'd3;
		end else if (m_s1 >= DEC_5) begin
			unit_c = UNIT_OHM; point_c = PT_3; k = 3'd2;
		end else if (m_s1 >= DEC_4) begin
			unit_c = UNIT_OHM; point_c = PT_2; k = 3'd1;
		end else if (m_s1 >= DEC_2) begin
			unit_c = UNIT_OHM; point_c = PT_1; k = 3'd0;
		end else begin
			unit_c = UNIT_NONE; point_c = PT_NONE; k = 3'd0;
		end

		case (range_q)
			RANGE_OFF:  over = 1'b0;
			RANGE_20R:  over = m_s1 > OVER_1;
			RANGE_200R: over = m_s1 > OVER_2;
			RANGE_2K:   over = m_s1 > OVER_3;
			RANGE_20K:  over = m_s1 > OVER_4;
			RANGE_200K: over = m_s1 > OVER_5;
			RANGE_2M:   over = m_s1 > OVER_6;
			default:    over = m_s1 > OVER_7;
		endcase

		case (range_q)
			RANGE_20R:  under = m_s1 < UNDER_1;
			RANGE_200R: under = m_s1 < UNDER_2;
			RANGE_2K:   under = m_s1 < UNDER_3;
			RANGE_20K:  under = m_s1 < UNDER_4;
			RANGE_200K: under = m_s1 < UNDER_5;
			RANGE_2M:   under = m_s1 < UNDER_6;
			RANGE_20M:  under = m_s1 < UNDER_7;
			default:    under = 1'b0;
		endcase
		under = under && !over;

		if (point_c == PT_NONE && !under) over = 1'b1;

		if (over) begin
			stat_c = STAT_OVER; point_n = PT_2;
		end else if (under) begin
			stat_c = STAT_UNDER; point_n = PT_2;
		end else begin
			stat_c = STAT_NORMAL; point_n = point_c;
		end
	end

	assign x    = XW'(m_s1 >> k);
	assign prod = 60'(x) * 60'(rcp_sel(k));
	assign q_n  = (k == 3'd0) ? m_s1[QW-1:0] : QW'(prod >> sh_sel(k));

	always_ff @(posedge clk) begin
		if (en1) m_s1 <= resistance_milliohm;
		if (en2) begin
			q_s2     <= q_n;
			point_s2 <= point_n;
			unit_s2  <= unit_c;
			stat_s2  <= stat_c;
		end
	end

	// split four digits by compare and subtract
	always_comb begin
		th = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (q_s2 >= QW'(i * 1000)) th = 4'(i);
		end
		rem1 = q_s2 - QW'(th) * QW'(1000);
		hu = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (rem1 >= QW'(i * 100)) hu = 4'(i);
		end
		rem2 = rem1 - QW'(hu) * QW'(100);
		te = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (rem2 >= QW'(i * 10)) te = 4'(i);
		end
		rem3 = rem2 - QW'(te) * QW'(10);
		on = rem3[3:0];
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			point_s3 <= point_s2;
			unit_s3  <= unit_s2;
			stat_s3  <= stat_s2;
			case (stat_s2)
				STAT_OVER: begin
					d0_s3 <= DIG_BLANK; d1_s3 <= DIG_ZERO;
					d2_s3 <= DIG_L;     d3_s3 <= DIG_BLANK;
				end
				STAT_UNDER: begin
					d0_s3 <= DIG_BLANK; d1_s3 <= DIG_ZERO;
					d2_s3 <= DIG_ZERO;  d3_s3 <= DIG_BLANK;
				end
				default: begin
					d0_s3 <= th; d1_s3 <= hu;
					d2_s3 <= te; d3_s3 <= on;
				end
			endcase
		end
	end

	assign frame_valid = v_s3;
	assign digit0      = d0_s3;
	assign digit1      = d1_s3;
	assign digit2      = d2_s3;
	assign digit3      = d3_s3;
	assign point_after = point_s3;
	assign unit_code   = unit_s3;
	assign status      = stat_s3;

endmodule
